// File: src/stp_pkg.sv
// shared types, character codes and class codes for the string to int64 parser
package stp_pkg;

    localparam int CH_W  = 8;
    localparam int VAL_W = 64;
    localparam int CNT_W = 5;
    localparam int CLS_W = 4;
    localparam int DIG_W = 4;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [CNT_W-1:0] DEC_MAX_DIGITS = 5'd21;
    localparam logic [CNT_W-1:0] DEC_CAP        = 5'd22;

    localparam logic [CH_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CHAR_ONE   = 8'h31;
    localparam logic [CH_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CH_W-1:0] CHAR_LO_B  = 8'h62;
    localparam logic [CH_W-1:0] CHAR_UP_B  = 8'h42;
    localparam logic [CH_W-1:0] CHAR_LO_X  = 8'h78;
    localparam logic [CH_W-1:0] CHAR_UP_X  = 8'h58;
    localparam logic [CH_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CH_W-1:0] CHAR_LO_F  = 8'h66;
    localparam logic [CH_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CHAR_UP_F  = 8'h46;

    typedef logic [CLS_W-1:0] t_cls;

    localparam t_cls CL_NUL   = 4'd0;
    localparam t_cls CL_ZERO  = 4'd1;
    localparam t_cls CL_ONE   = 4'd2;
    localparam t_cls CL_DEC   = 4'd3;
    localparam t_cls CL_HEXL  = 4'd4;
    localparam t_cls CL_B     = 4'd5;
    localparam t_cls CL_X     = 4'd6;
    localparam t_cls CL_MINUS = 4'd7;
    localparam t_cls CL_OTHER = 4'd8;

    typedef struct packed {
        t_cls             cls;
        logic [DIG_W-1:0] dig;
    } t_q_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: src/stp_intf.sv
// character and result channel interfaces
interface stp_ch_if import stp_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface stp_res_if import stp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value;
    logic                    too_long;

    modport source (output valid, output value, output too_long, input ready);
    modport sink   (input valid, input value, input too_long, output ready);
endinterface

// File: src/stp_front.sv
// front end: accepts characters and classifies them for the queue
module stp_front import stp_pkg::*; (
    stp_ch_if.sink   i_ch,
    input  t_q_stat  i_q_stat,
    output logic     o_push,
    output t_q_item  o_item
);

    function automatic t_q_item classify(input logic [CH_W-1:0] c);
        t_q_item r;
        r.cls = CL_OTHER;
        r.dig = '0;
        if (c == CHAR_NUL) begin
            r.cls = CL_NUL;
        end else if (c == CHAR_ZERO) begin
            r.cls = CL_ZERO;
        end else if (c == CHAR_ONE) begin
            r.cls = CL_ONE;
            r.dig = c[DIG_W-1:0];
        end else if (c > CHAR_ONE && c <= CHAR_NINE) begin
            r.cls = CL_DEC;
            r.dig = c[DIG_W-1:0];
        end else if (c == CHAR_MINUS) begin
            r.cls = CL_MINUS;
        end else if (c == CHAR_LO_B || c == CHAR_UP_B) begin
            r.cls = CL_B;
            r.dig = c[DIG_W-1:0] + 4'd9;
        end else if (c == CHAR_LO_X || c == CHAR_UP_X) begin
            r.cls = CL_X;
        end else if ((c >= CHAR_LO_A && c <= CHAR_LO_F) ||
                     (c >= CHAR_UP_A && c <= CHAR_UP_F)) begin
            r.cls = CL_HEXL;
            r.dig = c[DIG_W-1:0] + 4'd9;
        end
        return r;
    endfunction

    assign i_ch.ready = !i_q_stat.full;
    assign o_push     = i_ch.valid && !i_q_stat.full;
    assign o_item     = classify(i_ch.ch);

endmodule

// File: src/stp_queue.sv
// short queue of classified characters between front and back
module stp_queue import stp_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_q_item i_item,
    input  logic    i_pop,
    output t_q_item o_item,
    output t_q_stat o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_q_item       r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_stat.full  = (r_count == FULL);
    assign o_stat.empty = (r_count == '0);
    assign o_item       = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: src/stp_back.sv
// back end: parse state machine, accumulator and result register
module stp_back import stp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_stat    i_q_stat,
    input  t_q_item    i_item,
    output logic       o_pop,
    stp_res_if.source  o_res
);

    localparam logic [2:0] PH_LZ1   = 3'd0;
    localparam logic [2:0] PH_MINUS = 3'd1;
    localparam logic [2:0] PH_LZ2   = 3'd2;
    localparam logic [2:0] PH_BIN   = 3'd3;
    localparam logic [2:0] PH_HEX   = 3'd4;
    localparam logic [2:0] PH_DEC   = 3'd5;
    localparam logic [2:0] PH_DONE  = 3'd6;

    logic [2:0]       r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [VAL_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_o_valid, n_o_valid;
    logic [VAL_W-1:0] r_value, n_value;
    logic             r_too_long, n_too_long;

    logic             is_nul, is_bin, is_dec, is_hex;
    logic             do_choose, do_dec;
    logic [VAL_W-1:0] dig_ext;

    assign is_nul  = (i_item.cls == CL_NUL);
    assign is_bin  = (i_item.cls == CL_ZERO) || (i_item.cls == CL_ONE);
    assign is_dec  = is_bin || (i_item.cls == CL_DEC);
    assign is_hex  = is_dec || (i_item.cls == CL_HEXL) || (i_item.cls == CL_B);
    assign dig_ext = {{(VAL_W-DIG_W){1'b0}}, i_item.dig};

    // a terminator waits while the result register is still occupied
    assign o_pop = !i_q_stat.empty && (!is_nul || !r_o_valid || o_res.ready);

    assign o_res.valid    = r_o_valid;
    assign o_res.value    = r_value;
    assign o_res.too_long = r_too_long;

    always_comb begin
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_o_valid  = r_o_valid && !o_res.ready;
        n_value    = r_value;
        n_too_long = r_too_long;
        do_choose  = 1'b0;
        do_dec     = 1'b0;

        if (o_pop) begin
            if (is_nul) begin
                n_o_valid = 1'b1;
                if (r_cnt > DEC_MAX_DIGITS) begin
                    n_value    = '0;
                    n_too_long = 1'b1;
                end else begin
                    n_value    = r_neg ? (~r_acc + 1'b1) : r_acc;
                    n_too_long = 1'b0;
                end
                n_phase = PH_LZ1;
                n_neg   = 1'b0;
                n_acc   = '0;
                n_cnt   = '0;
            end else begin
                unique case (r_phase)
                    PH_LZ1: begin
                        if (i_item.cls == CL_MINUS) begin
                            n_neg   = !r_neg;
                            n_phase = PH_MINUS;
                        end else if (i_item.cls != CL_ZERO) begin
                            do_choose = 1'b1;
                        end
                    end
                    PH_MINUS: begin
                        if (i_item.cls == CL_MINUS) begin
                            n_neg = !r_neg;
                        end else if (i_item.cls == CL_ZERO) begin
                            n_phase = PH_LZ2;
                        end else begin
                            do_choose = 1'b1;
                        end
                    end
                    PH_LZ2: begin
                        if (i_item.cls != CL_ZERO) begin
                            do_choose = 1'b1;
                        end
                    end
                    PH_BIN: begin
                        if (is_bin) begin
                            n_acc = {r_acc[VAL_W-2:0], i_item.cls == CL_ONE};
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_HEX: begin
                        if (is_hex) begin
                            n_acc = {r_acc[VAL_W-5:0], i_item.dig};
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    PH_DEC: begin
                        if (is_dec) begin
                            do_dec = 1'b1;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase

                if (do_choose) begin
                    if (i_item.cls == CL_B) begin
                        n_phase = PH_BIN;
                    end else if (i_item.cls == CL_X) begin
                        n_phase = PH_HEX;
                    end else if (is_dec) begin
                        n_phase = PH_DEC;
                        do_dec  = 1'b1;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end

                // times ten as shift and add
                if (do_dec && r_cnt < DEC_CAP) begin
                    n_acc = {r_acc[VAL_W-4:0], 3'b000} + {r_acc[VAL_W-2:0], 1'b0} + dig_ext;
                    n_cnt = r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LZ1;
            r_neg     <= 1'b0;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_neg     <= n_neg;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_too_long <= n_too_long;
    end

endmodule

// File: src/string_to_int64_parser_top.sv
// top level of the streaming string to 64-bit integer parser
// Takes one character per clock while the queue has room and builds a signed 64-bit
// value in base 2, 10 or 16; a NUL transfer emits one result and clears the parse
// state. The front end classifies each character and writes it into a short queue;
// the back end runs the parse state machine and updates the accumulator (times ten as
// shift and add) once per cycle, so the sustained rate is one character per cycle
// unless a NUL waits on a full result register; only a NUL waits, other characters
// keep flowing while a result is held. A NUL passes the queue, then the result register.
module string_to_int64_parser_top import stp_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    stp_ch_if.sink    i_ch,
    stp_res_if.source o_res
);

    t_q_stat q_stat;
    t_q_item push_item;
    t_q_item q_item;
    logic    q_push;
    logic    q_pop;

    stp_front u_front (
        .i_ch     (i_ch),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_item   (push_item)
    );

    stp_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    stp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_item   (q_item),
        .o_pop    (q_pop),
        .o_res    (o_res)
    );

`ifndef NO_ASSERTIONS
    a_too_long_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.too_long) |-> (o_res.value == '0))
        else $error("too_long result with nonzero value");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_stat.empty && q_push) |=> !q_stat.empty)
        else $error("queue still empty after a transfer");

    a_result_from_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(q_pop && q_item.cls == CL_NUL))
        else $error("result without a terminator");
`endif

endmodule

// File: verif/tb_string_to_int64_parser_top.sv
// testbench for the string to int64 parser: character stream in, checked parse results out
module tb_string_to_int64_parser_top import stp_pkg::*; ();

    localparam int RANDOM_CHARS = 1050;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_ZERO2,
        PH_BIN,
        PH_HEX,
        PH_DEC,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    too_long;
    } t_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    stp_ch_if  ch_if ();
    stp_res_if res_if ();

    string_to_int64_parser_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_ch    (ch_if.sink),
        .o_res   (res_if.source)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [CH_W-1:0]  char_queue[$];
    t_result          expected_values[$];

    t_phase           ph;
    logic             neg;
    logic [VAL_W-1:0] acc;
    logic [CNT_W-1:0] ndig;

    int n_total;
    int n_sent;
    int n_checked;
    int n_errors;
    int n_too_long;
    int n_negative;
    int quiet;
    int src_idle;
    int snk_idle;

    function automatic void clear_parse();
        ph   = PH_LEAD;
        neg  = 1'b0;
        acc  = '0;
        ndig = '0;
    endfunction

    function automatic bit is_digit(input logic [CH_W-1:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic void add_decimal(input logic [CH_W-1:0] c);
        if (ndig < DEC_CAP) begin
            acc  = acc * VAL_W'(10) + VAL_W'(c - CHAR_ZERO);
            ndig = ndig + 1'b1;
        end
    endfunction

    function automatic void select_base(input logic [CH_W-1:0] c);
        if (c == CHAR_LO_B || c == CHAR_UP_B) begin
            ph = PH_BIN;
        end else if (c == CHAR_LO_X || c == CHAR_UP_X) begin
            ph = PH_HEX;
        end else if (is_digit(c)) begin
            ph = PH_DEC;
            add_decimal(c);
        end else begin
            ph = PH_DONE;
        end
    endfunction

    // advances the parse by one character; returns 1 when a result is due
    function automatic bit parse_char(input logic [CH_W-1:0] c, output t_result r);
        logic [DIG_W-1:0] nib;
        r = '0;
        if (c == CHAR_NUL) begin
            if (ndig > DEC_MAX_DIGITS) begin
                r.too_long = 1'b1;
            end else begin
                r.value = neg ? -acc : acc;
            end
            clear_parse();
            return 1'b1;
        end
        case (ph)
            PH_LEAD: begin
                if (c == CHAR_MINUS) begin
                    neg = ~neg;
                    ph  = PH_SIGN;
                end else if (c != CHAR_ZERO) begin
                    select_base(c);
                end
            end
            PH_SIGN: begin
                if (c == CHAR_MINUS) begin
                    neg = ~neg;
                end else if (c == CHAR_ZERO) begin
                    ph = PH_ZERO2;
                end else begin
                    select_base(c);
                end
            end
            PH_ZERO2: begin
                if (c != CHAR_ZERO) select_base(c);
            end
            PH_BIN: begin
                if (c == CHAR_ZERO || c == CHAR_ONE) begin
                    acc = {acc[VAL_W-2:0], c == CHAR_ONE};
                end else begin
                    ph = PH_DONE;
                end
            end
            PH_HEX: begin
                if (is_digit(c)) begin
                    nib = DIG_W'(c - CHAR_ZERO);
                    acc = {acc[VAL_W-5:0], nib};
                end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
                    nib = DIG_W'(c - CHAR_UP_A + 8'd10);
                    acc = {acc[VAL_W-5:0], nib};
                end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
                    nib = DIG_W'(c - CHAR_LO_A + 8'd10);
                    acc = {acc[VAL_W-5:0], nib};
                end else begin
                    ph = PH_DONE;
                end
            end
            PH_DEC: begin
                if (is_digit(c)) begin
                    add_decimal(c);
                end else begin
                    ph = PH_DONE;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    task automatic push_word(input string s);
        foreach (s[i]) char_queue.push_back(CH_W'(s[i]));
        char_queue.push_back(CHAR_NUL);
    endtask

    always_comb begin
        if (n_sent < n_total / 3) begin
            src_idle = 7;
            snk_idle = 77;
        end else if (n_sent < 2 * n_total / 3) begin
            src_idle = 77;
            snk_idle = 7;
        end else begin
            src_idle = 0;
            snk_idle = 0;
        end
    end

    // character driver
    always @(posedge clk) begin : char_driver
        t_result r;
        if (!rst_n) begin
            ch_if.valid <= 1'b0;
            ch_if.ch    <= CHAR_NUL;
        end else begin
            if (ch_if.valid && ch_if.ready) begin
                if (parse_char(ch_if.ch, r)) begin
                    expected_values.push_back(r);
                    if (r.too_long) n_too_long++;
                    if (r.value < 0) n_negative++;
                end
                n_sent++;
            end
            if (!ch_if.valid || ch_if.ready) begin
                if (char_queue.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
                    ch_if.valid <= 1'b1;
                    ch_if.ch    <= char_queue.pop_front();
                end else begin
                    ch_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : result_monitor
        t_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (expected_values.size() == 0) begin
                $error("unexpected result: value %0d too_long %0b", res_if.value,
                       res_if.too_long);
                n_errors++;
            end else begin
                want = expected_values.pop_front();
                if (res_if.value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, res_if.value);
                    n_errors++;
                end
                if (res_if.too_long !== want.too_long) begin
                    $error("too_long: expected %0b, got %0b", want.too_long,
                           res_if.too_long);
                    n_errors++;
                end
                n_checked++;
            end
        end
        res_if.ready <= rst_n && ($urandom_range(0, 99) >= snk_idle);
    end

    always @(posedge clk) begin
        if (!rst_n || (ch_if.valid && ch_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= STALL_LIMIT) begin
            $display("[string_to_int64_parser_top] ERROR");
            $finish;
        end
    end

    initial begin
        int kind;
        int len;
        int r;
        ch_if.valid  = 1'b0;
        ch_if.ch     = CHAR_NUL;
        res_if.ready = 1'b0;
        n_sent       = 0;
        n_checked    = 0;
        n_errors     = 0;
        n_too_long   = 0;
        n_negative   = 0;
        quiet        = 0;
        clear_parse();

        push_word("");
        push_word("00--0XfA9");
        push_word("-B101z7");
        char_queue.push_back(8'hff);
        char_queue.push_back(CHAR_NUL);
        push_word("-9");

        len = char_queue.size();
        while (char_queue.size() < len + RANDOM_CHARS) begin
            kind = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) char_queue.push_back(CHAR_ZERO);
            end
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) char_queue.push_back(CHAR_MINUS);
                repeat ($urandom_range(0, 2)) char_queue.push_back(CHAR_ZERO);
            end
            case (kind)
                0, 1, 2, 3: begin
                    r = ($urandom_range(0, 3) == 0) ? $urandom_range(19, 26)
                                                     : $urandom_range(1, 19);
                    repeat (r) char_queue.push_back(CH_W'(CHAR_ZERO + $urandom_range(0, 9)));
                end
                4, 5: begin
                    char_queue.push_back($urandom_range(0, 1) ? CHAR_LO_X : CHAR_UP_X);
                    repeat ($urandom_range(1, 20)) begin
                        r = $urandom_range(0, 21);
                        if (r < 10) char_queue.push_back(CH_W'(CHAR_ZERO + r));
                        else if (r < 16) char_queue.push_back(CH_W'(CHAR_UP_A + r - 10));
                        else char_queue.push_back(CH_W'(CHAR_LO_A + r - 16));
                    end
                end
                6, 7: begin
                    char_queue.push_back($urandom_range(0, 1) ? CHAR_LO_B : CHAR_UP_B);
                    r = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 70)
                                                     : $urandom_range(1, 24);
                    repeat (r) char_queue.push_back(CH_W'(CHAR_ZERO + $urandom_range(0, 1)));
                end
                default: begin
                    repeat ($urandom_range(0, 6))
                        char_queue.push_back(CH_W'($urandom_range(1, 255)));
                end
            endcase
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) char_queue.push_back(CH_W'($urandom_range(1, 255)));
            end
            char_queue.push_back(CHAR_NUL);
        end
        n_total = char_queue.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_total) @(posedge clk);
        while (expected_values.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d characters, checked %0d results", n_total, n_checked);
        $display("%0d over-long decimal runs, %0d negative values", n_too_long, n_negative);
        if (n_errors == 0) begin
            $display("[string_to_int64_parser_top] OK");
        end else begin
            $display("[string_to_int64_parser_top] ERROR");
        end
        $finish;
    end

endmodule

// File: string_to_int64_parser_top.f
src/stp_pkg.sv
src/stp_intf.sv
src/stp_front.sv
src/stp_queue.sv
src/stp_back.sv
src/string_to_int64_parser_top.sv
verif/tb_string_to_int64_parser_top.sv
